// ===== rtl/core/s2x_pkg.sv =====
`timescale 1ns / 1ps

package s2x_pkg;

    // Frame limits and the address widths that follow from them.
    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;
    localparam int C_COL_W    = $clog2(MAX_WIDTH);
    localparam int C_ROW_W    = $clog2(MAX_HEIGHT);

    // Field widths of the ports.
    localparam int C_PIX_W = 8;
    localparam int C_CRD_W = 10;
    localparam int C_CFG_W = 11;
    localparam int C_IDX_W = 2;

    // Configuration register indexes and their reset values.
    localparam logic [C_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [C_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
    localparam int C_RST_WIDTH  = 320;
    localparam int C_RST_HEIGHT = 240;

    // Result queue sizing.
    localparam int C_FIFO_DEPTH = 4;
    localparam int C_PTR_W      = $clog2(C_FIFO_DEPTH);
    localparam int C_CNT_W      = C_PTR_W + 1;
    localparam int C_MAX_RES    = 3;

    typedef logic [C_PIX_W-1:0] t_pix;

    typedef struct packed {
        t_pix tl;
        t_pix tr;
        t_pix bl;
        t_pix br;
    } t_quad;

    typedef struct packed {
        t_quad               quad;
        logic [C_CRD_W-1:0]  col;
        logic [C_CRD_W-1:0]  row;
        logic                last;
        logic                fend;
    } t_result;

    // Scale2x rule for one centre pixel e with neighbours b (up), d (left),
    // f (right) and h (down).
    function automatic t_quad scale2x(input t_pix b, input t_pix d, input t_pix e,
                                      input t_pix f, input t_pix h);
        t_quad q;
        q.tl = e;
        q.tr = e;
        q.bl = e;
        q.br = e;
        if ((b != h) && (d != f)) begin
            q.tl = (d == b) ? d : e;
            q.tr = (b == f) ? f : e;
            q.bl = (d == h) ? d : e;
            q.br = (h == f) ? f : e;
        end
        return q;
    endfunction

endpackage

// ===== rtl/core/scale2x_pixel_upscaler_core.sv =====
`timescale 1ns / 1ps

// Channel   | Direction | Handshake            | Payload
// pixel in  | input     | i_valid / o_stall    | i_pixel
// block out | output    | o_valid / i_stall    | o_top_left .. o_frame_end
// config    | input     | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
// One pixel is taken per cycle while the result queue has room. In the last row of a
// frame most pixels yield two blocks and the last pixel of a frame up to three, so
// there input waits for blocks to leave the queue. A block is at the output the cycle
// after its pixel transfer if the queue was empty. Reset is synchronous and clears
// counters and queue state; the line stores are not cleared. An output stall only holds
// back input once the four-entry result queue cannot take the blocks of the next pixel.

module scale2x_pixel_upscaler_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // Pixel input.
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [s2x_pkg::C_PIX_W-1:0] i_pixel,
    // Block output.
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [s2x_pkg::C_PIX_W-1:0] o_top_left,
    output logic [s2x_pkg::C_PIX_W-1:0] o_top_right,
    output logic [s2x_pkg::C_PIX_W-1:0] o_bottom_left,
    output logic [s2x_pkg::C_PIX_W-1:0] o_bottom_right,
    output logic [s2x_pkg::C_CRD_W-1:0] o_center_col,
    output logic [s2x_pkg::C_CRD_W-1:0] o_center_row,
    output logic                        o_last_of_run,
    output logic                        o_frame_end,
    // Configuration writes.
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [s2x_pkg::C_IDX_W-1:0] i_cfg_index,
    input  logic [s2x_pkg::C_CFG_W-1:0] i_cfg_data
);

    localparam int COL_W = s2x_pkg::C_COL_W;
    localparam int ROW_W = s2x_pkg::C_ROW_W;
    localparam int PTR_W = s2x_pkg::C_PTR_W;
    localparam int CNT_W = s2x_pkg::C_CNT_W;
    localparam int NRES  = s2x_pkg::C_MAX_RES;

    // Geometry, held as the index of the last column and last row.
    logic [COL_W-1:0] r_wlast;
    logic [ROW_W-1:0] r_hlast;
    logic [COL_W-1:0] r_col;
    logic [ROW_W-1:0] r_row;

    // Neighbour window and pixel history.
    s2x_pkg::t_pix r_e;
    s2x_pkg::t_pix r_f_wrap;
    s2x_pkg::t_pix r_b_wrap;
    logic          r_from_ram;
    s2x_pkg::t_pix r_pl;
    s2x_pkg::t_pix r_left;
    s2x_pkg::t_pix r_left2;
    s2x_pkg::t_pix r_row0;
    s2x_pkg::t_pix r_row1;
    s2x_pkg::t_pix r_above0;

    // Result queue.
    s2x_pkg::t_result r_fifo [s2x_pkg::C_FIFO_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_cnt;

    s2x_pkg::t_pix prior_q;
    s2x_pkg::t_pix above_q;
    s2x_pkg::t_pix f_cur;
    s2x_pkg::t_pix b_cur;

    logic             cfg_wr;
    logic             accept;
    logic             pop;
    logic             col_end;
    logic             last_row;
    logic             has_a;
    logic             has_b;
    logic             has_c;
    logic [CNT_W:0]   need;
    logic [CNT_W:0]   room_used;
    logic [CNT_W-1:0] n_cnt;
    logic [COL_W-1:0] n_col;
    logic [ROW_W-1:0] n_row;
    logic [COL_W-1:0] n_wlast;
    logic [ROW_W-1:0] n_hlast;

    s2x_pkg::t_result cand      [NRES];
    logic             cand_en   [NRES];
    logic [PTR_W-1:0] cand_slot [NRES];

    // Line stores: row just before the input row, and the row before that.
    s2x_ram #(
        .P_WIDTH (s2x_pkg::C_PIX_W),
        .P_DEPTH (s2x_pkg::MAX_WIDTH)
    ) u_prior_ram (
        .i_clk     (i_clk),
        .i_wr_en   (accept),
        .i_wr_addr (r_col),
        .i_wr_data (i_pixel),
        .i_rd_en   (accept),
        .i_rd_addr (r_col + COL_W'(2)),
        .o_rd_data (prior_q)
    );

    s2x_ram #(
        .P_WIDTH (s2x_pkg::C_PIX_W),
        .P_DEPTH (s2x_pkg::MAX_WIDTH)
    ) u_above_ram (
        .i_clk     (i_clk),
        .i_wr_en   (accept),
        .i_wr_addr (r_col),
        .i_wr_data (r_e),
        .i_rd_en   (accept),
        .i_rd_addr (r_col + COL_W'(1)),
        .o_rd_data (above_q)
    );

    // The right and upper neighbours come from the stores, except at the start of
    // a row, where the captured first pixels of the previous row stand in.
    assign f_cur = r_from_ram ? prior_q : r_f_wrap;
    assign b_cur = r_from_ram ? above_q : r_b_wrap;

    assign col_end  = (r_col == r_wlast);
    assign last_row = (r_row == r_hlast);
    assign has_a    = (r_row != '0);
    assign has_b    = last_row && (r_col != '0);
    assign has_c    = last_row && col_end;

    // Build the up to three blocks that the current pixel completes.
    always_comb begin
        s2x_pkg::t_pix a_b;
        s2x_pkg::t_pix a_d;
        s2x_pkg::t_pix a_f;
        s2x_pkg::t_pix b_d;
        s2x_pkg::t_pix b_b;
        s2x_pkg::t_pix c_b;

        a_b = (r_row == ROW_W'(1)) ? r_e : b_cur;
        a_d = (r_col == '0) ? r_e : r_pl;
        a_f = col_end ? r_e : f_cur;
        cand[0].quad = s2x_pkg::scale2x(a_b, a_d, r_e, a_f, i_pixel);
        cand[0].col  = s2x_pkg::C_CRD_W'(r_col);
        cand[0].row  = s2x_pkg::C_CRD_W'(r_row - ROW_W'(1));
        cand[0].last = !has_b && !has_c;
        cand[0].fend = 1'b0;

        b_d = (r_col == COL_W'(1)) ? r_left : r_left2;
        b_b = (r_row == '0) ? r_left : r_pl;
        cand[1].quad = s2x_pkg::scale2x(b_b, b_d, r_left, i_pixel, r_left);
        cand[1].col  = s2x_pkg::C_CRD_W'(r_col - COL_W'(1));
        cand[1].row  = s2x_pkg::C_CRD_W'(r_row);
        cand[1].last = !has_c;
        cand[1].fend = 1'b0;

        c_b = (r_row == '0) ? i_pixel : r_e;
        cand[2].quad = s2x_pkg::scale2x(c_b, r_left, i_pixel, i_pixel, i_pixel);
        cand[2].col  = s2x_pkg::C_CRD_W'(r_col);
        cand[2].row  = s2x_pkg::C_CRD_W'(r_row);
        cand[2].last = 1'b1;
        cand[2].fend = 1'b1;

        cand_en[0] = has_a;
        cand_en[1] = has_b;
        cand_en[2] = has_c;

        cand_slot[0] = r_wr_ptr;
        cand_slot[1] = r_wr_ptr + PTR_W'(has_a);
        cand_slot[2] = r_wr_ptr + PTR_W'(has_a) + PTR_W'(has_b);
    end

    // Queue occupancy and input flow control.
    assign pop       = o_valid && !i_stall;
    assign need      = (CNT_W+1)'(has_a) + (CNT_W+1)'(has_b) + (CNT_W+1)'(has_c);
    assign room_used = (CNT_W+1)'(r_cnt) - (CNT_W+1)'(pop) + need;
    assign o_stall   = (room_used > (CNT_W+1)'(s2x_pkg::C_FIFO_DEPTH));
    assign accept    = i_valid && !o_stall;
    assign n_cnt     = r_cnt + (accept ? CNT_W'(need) : '0) - CNT_W'(pop);

    assign cfg_wr      = i_cfg_valid && o_cfg_ready;
    assign o_cfg_ready = 1'b1;

    // Effective geometry from the written value, clamped to the supported range.
    always_comb begin
        n_wlast = r_wlast;
        n_hlast = r_hlast;
        if (cfg_wr) begin
            unique case (i_cfg_index)
                s2x_pkg::REG_FRAME_WIDTH: begin
                    if (32'(i_cfg_data) > s2x_pkg::MAX_WIDTH) begin
                        n_wlast = COL_W'(s2x_pkg::MAX_WIDTH - 1);
                    end else if (i_cfg_data < s2x_pkg::C_CFG_W'(2)) begin
                        n_wlast = COL_W'(1);
                    end else begin
                        n_wlast = COL_W'(i_cfg_data - s2x_pkg::C_CFG_W'(1));
                    end
                end
                s2x_pkg::REG_FRAME_HEIGHT: begin
                    if (32'(i_cfg_data) > s2x_pkg::MAX_HEIGHT) begin
                        n_hlast = ROW_W'(s2x_pkg::MAX_HEIGHT - 1);
                    end else if (i_cfg_data < s2x_pkg::C_CFG_W'(1)) begin
                        n_hlast = '0;
                    end else begin
                        n_hlast = ROW_W'(i_cfg_data - s2x_pkg::C_CFG_W'(1));
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Raster position after this transfer.
    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (cfg_wr && (i_cfg_index == s2x_pkg::REG_FRAME_WIDTH ||
                       i_cfg_index == s2x_pkg::REG_FRAME_HEIGHT)) begin
            n_col = '0;
            n_row = '0;
        end else if (accept) begin
            if (col_end) begin
                n_col = '0;
                n_row = last_row ? '0 : r_row + ROW_W'(1);
            end else begin
                n_col = r_col + COL_W'(1);
            end
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wlast    <= COL_W'(s2x_pkg::C_RST_WIDTH - 1);
            r_hlast    <= ROW_W'(s2x_pkg::C_RST_HEIGHT - 1);
            r_col      <= '0;
            r_row      <= '0;
            r_from_ram <= 1'b0;
            r_wr_ptr   <= '0;
            r_rd_ptr   <= '0;
            r_cnt      <= '0;
        end else begin
            r_wlast <= n_wlast;
            r_hlast <= n_hlast;
            r_col   <= n_col;
            r_row   <= n_row;
            r_cnt   <= n_cnt;
            if (accept) begin
                r_from_ram <= !col_end;
                r_wr_ptr   <= r_wr_ptr + PTR_W'(need);
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + PTR_W'(1);
            end
        end
    end

    // Window and history registers, advanced on each input transfer.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_pl    <= r_e;
            r_left  <= i_pixel;
            r_left2 <= r_left;
            if (col_end) begin
                r_e      <= r_row0;
                r_f_wrap <= (r_col == COL_W'(1)) ? i_pixel : r_row1;
                r_b_wrap <= r_above0;
            end else begin
                r_e <= f_cur;
            end
            if (r_col == '0) begin
                r_row0   <= i_pixel;
                r_above0 <= r_e;
            end
            if (r_col == COL_W'(1)) begin
                r_row1 <= i_pixel;
            end
        end
    end

    // Push the completed blocks into the queue in raster order.
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < NRES; k++) begin
            if (accept && cand_en[k]) begin
                r_fifo[cand_slot[k]] <= cand[k];
            end
        end
    end

    // Output side reads the queue head.
    assign o_valid        = (r_cnt != '0);
    assign o_top_left     = r_fifo[r_rd_ptr].quad.tl;
    assign o_top_right    = r_fifo[r_rd_ptr].quad.tr;
    assign o_bottom_left  = r_fifo[r_rd_ptr].quad.bl;
    assign o_bottom_right = r_fifo[r_rd_ptr].quad.br;
    assign o_center_col   = r_fifo[r_rd_ptr].col;
    assign o_center_row   = r_fifo[r_rd_ptr].row;
    assign o_last_of_run  = r_fifo[r_rd_ptr].last;
    assign o_frame_end    = r_fifo[r_rd_ptr].fend;

endmodule

// ===== rtl/core/s2x_ram.sv =====
`timescale 1ns / 1ps

module s2x_ram #(
    parameter int P_WIDTH = 8,
    parameter int P_DEPTH = 1024
) (
    input  logic                       i_clk,
    input  logic                       i_wr_en,
    input  logic [$clog2(P_DEPTH)-1:0] i_wr_addr,
    input  logic [P_WIDTH-1:0]         i_wr_data,
    input  logic                       i_rd_en,
    input  logic [$clog2(P_DEPTH)-1:0] i_rd_addr,
    output logic [P_WIDTH-1:0]         o_rd_data
);

    logic [P_WIDTH-1:0] r_mem [P_DEPTH];
    logic [P_WIDTH-1:0] r_rd_data;

    // One write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== sim/scale2x_pixel_upscaler_core_tb.sv =====
`timescale 1ns / 1ps

module scale2x_pixel_upscaler_core_tb;

    import s2x_pkg::*;

    // Register indexes beyond the two real registers; writes to them are dropped.
    localparam logic [C_IDX_W-1:0] IDX_SPARE_LO = 2'd2;
    localparam logic [C_IDX_W-1:0] IDX_SPARE_HI = 2'd3;

    localparam int SETTLE_CYCLES  = 16;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RESET_PIXELS   = 24;
    localparam int RANDOM_PIXELS  = 170;
    localparam int SCRIPT_LEN     = 33;

    typedef struct packed {
        t_pix               tl;
        t_pix               tr;
        t_pix               bl;
        t_pix               br;
        logic [C_CRD_W-1:0] col;
        logic [C_CRD_W-1:0] row;
        logic               last;
        logic               fend;
    } t_epx_block;

    typedef enum logic {STEP_CFG, STEP_PIXEL} t_step_kind;

    typedef struct {
        t_step_kind         kind;
        logic [C_IDX_W-1:0] index;
        logic [C_CFG_W-1:0] value;
        t_pix               pixel;
        logic               typed;
        t_epx_block         want;
    } t_script_step;

    localparam t_epx_block NO_BLOCK = '0;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_stall;
    t_pix               i_pixel = '0;
    logic               o_valid;
    logic               i_stall = 1'b0;
    t_pix               o_top_left;
    t_pix               o_top_right;
    t_pix               o_bottom_left;
    t_pix               o_bottom_right;
    logic [C_CRD_W-1:0] o_center_col;
    logic [C_CRD_W-1:0] o_center_row;
    logic               o_last_of_run;
    logic               o_frame_end;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic [C_IDX_W-1:0] i_cfg_index = '0;
    logic [C_CFG_W-1:0] i_cfg_data = '0;

    // Predictor state: two earlier rows, two held pixels, raster position and registers.
    t_pix               upper_line [MAX_WIDTH];
    t_pix               prev_line [MAX_WIDTH];
    t_pix               left_px = '0;
    t_pix               upleft_px = '0;
    int unsigned        col_pos = 0;
    int unsigned        row_pos = 0;
    logic [C_CFG_W-1:0] width_reg = C_CFG_W'(C_RST_WIDTH);
    logic [C_CFG_W-1:0] height_reg = C_CFG_W'(C_RST_HEIGHT);

    t_epx_block pending_blocks [$];
    int         mismatch_count = 0;
    int         idle_cycles = 0;
    bit         no_idle = 1'b0;
    t_pix       tones [3];

    // Directed stimulus: ignored indexes, clamped sizes, a single-row frame, a frame where
    // the corner rule fires, and a restart in the middle of a frame.
    t_script_step script [SCRIPT_LEN] = '{
        '{STEP_CFG,   IDX_SPARE_LO,     11'h7FF, 8'h00, 1'b0, NO_BLOCK},
        '{STEP_CFG,   IDX_SPARE_HI,     11'h000, 8'h00, 1'b0, NO_BLOCK},
        '{STEP_CFG,   REG_FRAME_WIDTH,  11'd0,   8'h00, 1'b0, NO_BLOCK},
        '{STEP_CFG,   REG_FRAME_HEIGHT, 11'd0,   8'h00, 1'b0, NO_BLOCK},
        '{STEP_PIXEL, REG_FRAME_WIDTH,  11'd0,   8'h00, 1'b0, NO_BLOCK},
        '{STEP_PIXEL, REG_FRAME_WIDTH,  11'd0,   8'hFF, 1'b1,
          '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 10'd1, 10'd0, 1'b1, 1'b1}},
        '{STEP_CFG,   REG_FRAME_WIDTH,  11'd3,   8'h00, 1'b0, NO_BLOCK},
        '{STEP_CFG,   REG_FRAME_HEIGHT, 11'd3,   8'h00, 1'b0, NO_BLOCK},
        '{STEP_PIXEL, REG_FRAME_WIDTH,  11'd0,   8'h05, 1'b0, NO_BLOCK},
        '{STEP_PIXEL, REG_FRAME_WIDTH,  11'd0,   8'h07, 1'b0, NO_BLOCK},
        '{STEP_PIXEL, REG_FRAME_WIDTH,  11'd0,   8'h09, 1'b0, NO_BLOCK},
        '{STEP_PIXEL, REG_FRAME_WIDTH,  11'd0,   8'h07, 1'b0, NO_BLOCK},
        '{STEP_PIXEL, REG_FRAME_WIDTH,  11'd0,   8'h30, 1'b0, NO_BLOCK},
        '{STEP_PIXEL, REG_FRAME_WIDTH,  11'd0,   8'h09, 1'b0, NO_BLOCK},
        '{STEP_PIXEL, REG_FRAME_WIDTH,  11'd0,   8'h0B, 1'b0, NO_BLOCK},
        '{STEP_PIXEL, REG_FRAME_WIDTH,  11'd0,   8'h09, 1'b0, NO_BLOCK},
        '{STEP_PIXEL, REG_FRAME_WIDTH,  11'd0,   8'h0D, 1'b0, NO_BLOCK},
        '{STEP_CFG,   REG_FRAME_WIDTH,  11'd4,   8'h00, 1'b0, NO_BLOCK},
        '{STEP_CFG,   REG_FRAME_HEIGHT, 11'd2,   8'h00, 1'b0, NO_BLOCK},
        '{STEP_PIXEL, REG_FRAME_WIDTH,  11'd0,   8'h12, 1'b0, NO_BLOCK},
        '{STEP_PIXEL, REG_FRAME_WIDTH,  11'd0,   8'h34, 1'b0, NO_BLOCK},
        '{STEP_PIXEL, REG_FRAME_WIDTH,  11'd0,   8'h56, 1'b0, NO_BLOCK},
        '{STEP_PIXEL, REG_FRAME_WIDTH,  11'd0,   8'h78, 1'b0, NO_BLOCK},
        '{STEP_PIXEL, REG_FRAME_WIDTH,  11'd0,   8'h9A, 1'b1,
          '{8'h12, 8'h12, 8'h12, 8'h12, 10'd0, 10'd0, 1'b1, 1'b0}},
        '{STEP_CFG,   REG_FRAME_HEIGHT, 11'd2,   8'h00, 1'b0, NO_BLOCK},
        '{STEP_PIXEL, REG_FRAME_WIDTH,  11'd0,   8'h55, 1'b0, NO_BLOCK},
        '{STEP_PIXEL, REG_FRAME_WIDTH,  11'd0,   8'h55, 1'b0, NO_BLOCK},
        '{STEP_PIXEL, REG_FRAME_WIDTH,  11'd0,   8'h55, 1'b0, NO_BLOCK},
        '{STEP_PIXEL, REG_FRAME_WIDTH,  11'd0,   8'h55, 1'b0, NO_BLOCK},
        '{STEP_PIXEL, REG_FRAME_WIDTH,  11'd0,   8'h55, 1'b0, NO_BLOCK},
        '{STEP_PIXEL, REG_FRAME_WIDTH,  11'd0,   8'h55, 1'b0, NO_BLOCK},
        '{STEP_PIXEL, REG_FRAME_WIDTH,  11'd0,   8'h55, 1'b0, NO_BLOCK},
        '{STEP_PIXEL, REG_FRAME_WIDTH,  11'd0,   8'h55, 1'b1,
          '{8'h55, 8'h55, 8'h55, 8'h55, 10'd3, 10'd1, 1'b1, 1'b1}}
    };

    scale2x_pixel_upscaler_core DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_pixel        (i_pixel),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_top_left     (o_top_left),
        .o_top_right    (o_top_right),
        .o_bottom_left  (o_bottom_left),
        .o_bottom_right (o_bottom_right),
        .o_center_col   (o_center_col),
        .o_center_row   (o_center_row),
        .o_last_of_run  (o_last_of_run),
        .o_frame_end    (o_frame_end),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // A corner copies the edge neighbor shared by its two sides when those agree, but only
    // when neither the vertical nor the horizontal pair matches.
    function automatic t_epx_block epx_block(input t_pix b, input t_pix d, input t_pix e,
                                             input t_pix f, input t_pix h,
                                             input int unsigned col, input int unsigned row,
                                             input logic fend);
        t_epx_block blk;
        blk = '{e, e, e, e, col[C_CRD_W-1:0], row[C_CRD_W-1:0], 1'b0, fend};
        if (b != h && d != f) begin
            if (d == b) blk.tl = d;
            if (b == f) blk.tr = f;
            if (d == h) blk.bl = d;
            if (h == f) blk.br = f;
        end
        return blk;
    endfunction

    // Advance the predictor by one pixel and queue the blocks that it completes.
    function automatic void upscale_pixel(input t_pix px);
        int unsigned w;
        int unsigned h;
        int unsigned c;
        int unsigned r;
        int          n;
        t_pix        old_up;
        t_pix        b;
        t_pix        d;
        t_pix        e;
        t_pix        f;
        w = 32'(width_reg);
        h = 32'(height_reg);
        if (w < 2) w = 2;
        if (w > MAX_WIDTH) w = MAX_WIDTH;
        if (h < 1) h = 1;
        if (h > MAX_HEIGHT) h = MAX_HEIGHT;
        c = col_pos;
        r = row_pos;
        n = 0;
        if (c >= w || r >= h) begin
            c = 0;
            r = 0;
        end
        old_up = prev_line[c];

        // The pixel above is complete now that its lower neighbor has arrived.
        if (r >= 1) begin
            e = old_up;
            b = (r == 1) ? e : upper_line[c];
            d = (c == 0) ? e : upleft_px;
            f = (c == w - 1) ? e : prev_line[c + 1];
            pending_blocks.push_back(epx_block(b, d, e, f, px, c, r - 1, 1'b0));
            n++;
        end

        // In the bottom row the left neighbor is complete, and the row end closes itself.
        if (r == h - 1) begin
            if (c >= 1) begin
                e = left_px;
                d = (c == 1) ? e : prev_line[c - 2];
                b = (r == 0) ? e : upleft_px;
                pending_blocks.push_back(epx_block(b, d, e, px, e, c - 1, r, 1'b0));
                n++;
            end
            if (c == w - 1) begin
                b = (r == 0) ? px : old_up;
                pending_blocks.push_back(epx_block(b, left_px, px, px, px, c, r, 1'b1));
                n++;
            end
        end
        if (n > 0) pending_blocks[pending_blocks.size() - 1].last = 1'b1;

        upper_line[c] = old_up;
        prev_line[c] = px;
        upleft_px = old_up;
        left_px = px;
        c++;
        if (c >= w) begin
            c = 0;
            r++;
            if (r >= h) r = 0;
        end
        col_pos = c;
        row_pos = r;
    endfunction

    function automatic void check_field(input string name, input logic [15:0] want,
                                        input logic [15:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatch_count++;
        end
    endfunction

    // Mostly a few recurring tones so that neighbors match often; sometimes any value.
    function automatic t_pix pick_pixel();
        if ($urandom_range(0, 3) == 0) return t_pix'($urandom);
        return tones[$urandom_range(0, 2)];
    endfunction

    function automatic void new_tones();
        foreach (tones[k]) tones[k] = t_pix'($urandom);
    endfunction

    task automatic send_pixel(input t_pix px);
        if (!no_idle && $urandom_range(0, 99) < 15) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_pixel <= px;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        upscale_pixel(px);
    endtask

    // Let every queued block come out, then give rows that yield nothing time to settle.
    task automatic drain_blocks();
        i_valid <= 1'b0;
        while (pending_blocks.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_register(input logic [C_IDX_W-1:0] idx,
                                  input logic [C_CFG_W-1:0] val);
        drain_blocks();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        case (idx)
            REG_FRAME_WIDTH: width_reg = val;
            REG_FRAME_HEIGHT: height_reg = val;
            default: return;
        endcase
        col_pos = 0;
        row_pos = 0;
    endtask

    // Output side: random stall, block checking and the watchdog.
    always @(posedge i_clk) begin
        t_epx_block want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_blocks.size() == 0) begin
                $error("block for column %0d row %0d arrived with nothing expected",
                       o_center_col, o_center_row);
                mismatch_count++;
            end else begin
                want = pending_blocks.pop_front();
                check_field("top_left", 16'(want.tl), 16'(o_top_left));
                check_field("top_right", 16'(want.tr), 16'(o_top_right));
                check_field("bottom_left", 16'(want.bl), 16'(o_bottom_left));
                check_field("bottom_right", 16'(want.br), 16'(o_bottom_right));
                check_field("center_col", 16'(want.col), 16'(o_center_col));
                check_field("center_row", 16'(want.row), 16'(o_center_row));
                check_field("last_of_run", 16'(want.last), 16'(o_last_of_run));
                check_field("frame_end", 16'(want.fend), 16'(o_frame_end));
            end
        end
        i_stall <= !no_idle && ($urandom_range(0, 99) < 13);

        if ((i_valid && !o_stall) || (o_valid && !i_stall) || (i_cfg_valid && o_cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        int                 random_sent;
        int                 count;
        logic [C_CFG_W-1:0] w_raw;
        logic [C_CFG_W-1:0] h_raw;
        foreach (upper_line[k]) begin
            upper_line[k] = '0;
            prev_line[k] = '0;
        end
        new_tones();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset sizes: the start of a wide first row, which completes no block yet.
        repeat (RESET_PIXELS) send_pixel(pick_pixel());

        foreach (script[k]) begin
            if (script[k].kind == STEP_CFG) begin
                write_register(script[k].index, script[k].value);
            end else begin
                send_pixel(script[k].pixel);
                if (script[k].typed)
                    pending_blocks[pending_blocks.size() - 1] = script[k].want;
            end
        end

        // Random phases, mostly small frames; some phases only poke a spare index,
        // which must leave the frame position alone.
        random_sent = 0;
        while (random_sent < RANDOM_PIXELS) begin
            if ($urandom_range(0, 3) == 0) begin
                write_register($urandom_range(0, 1) ? IDX_SPARE_LO : IDX_SPARE_HI,
                               C_CFG_W'($urandom));
            end else begin
                case ($urandom_range(0, 9))
                    0: w_raw = C_CFG_W'($urandom_range(0, 1));
                    1: w_raw = C_CFG_W'($urandom_range(1025, 2047));
                    default: w_raw = C_CFG_W'($urandom_range(2, 7));
                endcase
                case ($urandom_range(0, 9))
                    0: h_raw = '0;
                    1: h_raw = C_CFG_W'($urandom_range(1025, 2047));
                    2: h_raw = C_CFG_W'(1);
                    default: h_raw = C_CFG_W'($urandom_range(2, 5));
                endcase
                if ($urandom_range(0, 1)) begin
                    write_register(REG_FRAME_WIDTH, w_raw);
                    write_register(REG_FRAME_HEIGHT, h_raw);
                end else begin
                    write_register(REG_FRAME_HEIGHT, h_raw);
                    write_register(REG_FRAME_WIDTH, w_raw);
                end
            end
            new_tones();
            count = $urandom_range(1, 60);
            repeat (count) send_pixel(pick_pixel());
            random_sent += count;
        end

        // A long stretch at full rate on both sides: two whole frames back to back.
        no_idle = 1'b1;
        write_register(REG_FRAME_WIDTH, 11'd7);
        write_register(REG_FRAME_HEIGHT, 11'd5);
        repeat (70) send_pixel(pick_pixel());
        no_idle = 1'b0;

        drain_blocks();
        if (mismatch_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
